### rtl/neighbour_request_frame_builder_unit_assert.svh
// Assertion macros for the neighbour request frame builder checker.
`ifndef NEIGHBOUR_REQUEST_FRAME_BUILDER_UNIT_ASSERT_SVH
`define NEIGHBOUR_REQUEST_FRAME_BUILDER_UNIT_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define NRFB_ASSERT_NOW(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define NRFB_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/nrfb_pkg.sv
// Shared types, constants and frame word layout for the frame builder.
`default_nettype none

package nrfb_pkg;

    localparam int WORD_IDX_W = 4;

    localparam logic [1:0] CFG_OWN_MAC     = 2'd0;
    localparam logic [1:0] CFG_SOURCE_IPV4 = 2'd1;
    localparam logic [1:0] CFG_SOURCE_IP6H = 2'd2;
    localparam logic [1:0] CFG_SOURCE_IP6L = 2'd3;

    localparam logic KIND_ARP = 1'b0;
    localparam logic KIND_NS  = 1'b1;

    localparam logic [WORD_IDX_W-1:0] ARP_LAST_IDX = 4'd5;
    localparam logic [WORD_IDX_W-1:0] NS_LAST_IDX  = 4'd10;

    localparam logic [3:0] FULL_BYTES     = 4'd8;
    localparam logic [3:0] ARP_LAST_BYTES = 4'd2;
    localparam logic [3:0] NS_LAST_BYTES  = 4'd6;

    // Fixed checksum terms: ff02, 0001, icmp type/code 8700, option 0101,
    // plus pseudo-header length 32 and next header 58.
    localparam logic [16:0] CSUM_FIXED = 17'h0ff02 + 17'h00001 + 17'h08700
                                       + 17'h00101 + 17'd32 + 17'd58;

    typedef struct packed {
        logic [47:0] own_mac;
        logic [31:0] source_ipv4;
        logic [63:0] source_ipv6_high;
        logic [63:0] source_ipv6_low;
    } cfg_t;

    typedef struct packed {
        logic        kind;
        logic [63:0] target_high;
        logic [63:0] target_low;
    } req_t;

    // One 64-bit frame word, earliest byte in the top bits, padding zero.
    function automatic logic [63:0] frame_word(input req_t r, input cfg_t c,
                                               input logic [15:0] csum,
                                               input logic [WORD_IDX_W-1:0] idx);
        logic [63:0] w;
        w = 64'h0;
        if (r.kind == KIND_NS) begin
            case (idx)
                4'd0:    w = {24'h3333ff, r.target_low[23:0], c.own_mac[47:32]};
                4'd1:    w = {c.own_mac[31:0], 32'h86dd_6000};
                4'd2:    w = {48'h0000_0020_3aff, c.source_ipv6_high[63:48]};
                4'd3:    w = {c.source_ipv6_high[47:0], c.source_ipv6_low[63:48]};
                4'd4:    w = {c.source_ipv6_low[47:0], 16'hff02};
                4'd5:    w = 64'h0;
                4'd6:    w = {24'h0001ff, r.target_low[23:0], 16'h8700};
                4'd7:    w = {csum, 32'h0, r.target_high[63:48]};
                4'd8:    w = {r.target_high[47:0], r.target_low[63:48]};
                4'd9:    w = {r.target_low[47:0], 16'h0101};
                4'd10:   w = {c.own_mac, 16'h0};
                default: w = 64'h0;
            endcase
        end else begin
            case (idx)
                4'd0:    w = {48'hffff_ffff_ffff, c.own_mac[47:32]};
                4'd1:    w = {c.own_mac[31:0], 32'h0806_0001};
                4'd2:    w = {48'h0800_0604_0001, c.own_mac[47:32]};
                4'd3:    w = {c.own_mac[31:0], c.source_ipv4};
                4'd4:    w = {48'h0, r.target_low[31:16]};
                4'd5:    w = {r.target_low[15:0], 48'h0};
                default: w = 64'h0;
            endcase
        end
        return w;
    endfunction

endpackage

`default_nettype wire

### rtl/nrfb_csum.sv
// Three-stage ICMPv6 checksum pipeline; request fields travel alongside.
`default_nettype none

module nrfb_csum import nrfb_pkg::*; (
    input  wire         aclk,
    input  wire         aresetn,
    input  wire cfg_t   cfg,
    input  wire         in_valid,
    output logic        in_ready,
    input  wire req_t   in_req,
    output logic        out_valid,
    input  wire         out_ready,
    output req_t        out_req,
    output logic [15:0] out_csum
);

    logic        v1_reg, v2_reg, v3_reg;
    req_t        req1_reg, req2_reg, req3_reg;
    logic [18:0] pa_reg, pb_reg, pc_reg, pd_reg;
    logic [18:0] pa_next, pb_next, pc_next, pd_next;
    logic [16:0] fold1_reg, fold1_next;
    logic [20:0] sum4;
    logic [16:0] fold2;
    logic [15:0] csum_reg, csum_next;
    logic        rdy1, rdy2, rdy3;

    assign rdy3     = !v3_reg || out_ready;
    assign rdy2     = !v2_reg || rdy3;
    assign rdy1     = !v1_reg || rdy2;
    assign in_ready = rdy1;

    // Stage 1: four partial sums of 16-bit terms
    always_comb begin
        pa_next = {3'b0, cfg.source_ipv6_high[63:48]} + {3'b0, cfg.source_ipv6_high[47:32]}
                + {3'b0, cfg.source_ipv6_high[31:16]} + {3'b0, cfg.source_ipv6_high[15:0]}
                + {3'b0, cfg.own_mac[47:32]};
        pb_next = {3'b0, cfg.source_ipv6_low[63:48]} + {3'b0, cfg.source_ipv6_low[47:32]}
                + {3'b0, cfg.source_ipv6_low[31:16]} + {3'b0, cfg.source_ipv6_low[15:0]}
                + {3'b0, cfg.own_mac[31:16]} + {3'b0, cfg.own_mac[15:0]};
        pc_next = {3'b0, in_req.target_high[63:48]} + {3'b0, in_req.target_high[47:32]}
                + {3'b0, in_req.target_high[31:16]} + {3'b0, in_req.target_high[15:0]}
                + {11'h0ff, in_req.target_low[23:16]};
        pd_next = {3'b0, in_req.target_low[63:48]} + {3'b0, in_req.target_low[47:32]}
                + {3'b0, in_req.target_low[31:16]} + {3'b0, in_req.target_low[15:0]}
                + {3'b0, in_req.target_low[15:0]} + {2'b0, CSUM_FIXED};
    end

    // Stage 2: combine and fold once; stage 3: fold again and complement
    always_comb begin
        sum4       = {2'b0, pa_reg} + {2'b0, pb_reg} + {2'b0, pc_reg} + {2'b0, pd_reg};
        fold1_next = {1'b0, sum4[15:0]} + {12'b0, sum4[20:16]};
        fold2      = {1'b0, fold1_reg[15:0]} + {16'b0, fold1_reg[16]};
        csum_next  = ~fold2[15:0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end else begin
            if (rdy1) v1_reg <= in_valid;
            if (rdy2) v2_reg <= v1_reg;
            if (rdy3) v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (rdy1 && in_valid) begin
            req1_reg <= in_req;
            pa_reg   <= pa_next;
            pb_reg   <= pb_next;
            pc_reg   <= pc_next;
            pd_reg   <= pd_next;
        end
        if (rdy2 && v1_reg) begin
            req2_reg  <= req1_reg;
            fold1_reg <= fold1_next;
        end
        if (rdy3 && v2_reg) begin
            req3_reg <= req2_reg;
            csum_reg <= csum_next;
        end
    end

    assign out_valid = v3_reg;
    assign out_req   = req3_reg;
    assign out_csum  = csum_reg;

endmodule

`default_nettype wire

### rtl/nrfb_ser.sv
// Word serializer: holds one request and emits its frame into an output register.
`default_nettype none

module nrfb_ser import nrfb_pkg::*; (
    input  wire         aclk,
    input  wire         aresetn,
    input  wire cfg_t   cfg,
    input  wire         in_valid,
    output logic        in_ready,
    input  wire req_t   in_req,
    input  wire  [15:0] in_csum,
    output logic        m_valid,
    input  wire         m_ready,
    output logic [63:0] m_frame_word,
    output logic [3:0]  m_valid_bytes,
    output logic        m_last_word
);

    logic                  busy_reg, busy_next;
    logic [WORD_IDX_W-1:0] idx_reg, idx_next;
    req_t                  req_reg;
    logic [15:0]           csum_reg;
    logic                  m_valid_reg, m_valid_next;
    logic [63:0]           word_reg;
    logic [3:0]            bytes_reg, bytes_next;
    logic                  last_reg;
    logic                  load_out, last, take;

    assign load_out = !m_valid_reg || m_ready;
    assign last     = (req_reg.kind == KIND_NS) ? (idx_reg == NS_LAST_IDX)
                                                : (idx_reg == ARP_LAST_IDX);
    // next request may enter as the final word of the current one goes out
    assign in_ready = !busy_reg || (load_out && last);
    assign take     = in_valid && in_ready;

    always_comb begin
        busy_next    = busy_reg;
        idx_next     = idx_reg;
        m_valid_next = m_valid_reg;
        if (load_out) m_valid_next = busy_reg;
        if (busy_reg && load_out) begin
            if (last) begin
                busy_next = 1'b0;
                idx_next  = '0;
            end else begin
                idx_next = idx_reg + 1'b1;
            end
        end
        if (take) begin
            busy_next = 1'b1;
            idx_next  = '0;
        end
    end

    always_comb begin
        bytes_next = FULL_BYTES;
        if (last) bytes_next = (req_reg.kind == KIND_NS) ? NS_LAST_BYTES : ARP_LAST_BYTES;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg    <= 1'b0;
            idx_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            busy_reg    <= busy_next;
            idx_reg     <= idx_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (take) begin
            req_reg  <= in_req;
            csum_reg <= in_csum;
        end
        if (busy_reg && load_out) begin
            word_reg  <= frame_word(req_reg, cfg, csum_reg, idx_reg);
            bytes_reg <= bytes_next;
            last_reg  <= last;
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_frame_word  = word_reg;
    assign m_valid_bytes = bytes_reg;
    assign m_last_word   = last_reg;

endmodule

`default_nettype wire

### rtl/neighbour_request_frame_builder_unit.sv
// The first word of a frame passes the three checksum stages, the serializer's request
// register and its output word register before it is on the m_ ports. Throughput: one
// frame word per cycle while m_ready is high, set by the output serializer.
// Three checksum stages buffer further requests while a frame is sent.
// Reset (aresetn low, synchronous) empties all stages and zeroes the config.
`default_nettype none

module neighbour_request_frame_builder_unit import nrfb_pkg::*; (
    input  wire         aclk,
    input  wire         aresetn,
    input  wire         cfg_wr_en,
    input  wire  [1:0]  cfg_index,
    input  wire  [63:0] cfg_wr_data,
    input  wire         s_valid,
    output logic        s_ready,
    input  wire         s_opcode,
    input  wire  [63:0] s_target_high,
    input  wire  [63:0] s_target_low,
    output logic        m_valid,
    input  wire         m_ready,
    output logic [63:0] m_frame_word,
    output logic [3:0]  m_valid_bytes,
    output logic        m_last_word
);

    cfg_t        cfg_reg;
    req_t        s_req;
    req_t        cs_req;
    logic        cs_valid, cs_ready;
    logic [15:0] cs_csum;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= '0;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                CFG_OWN_MAC:     cfg_reg.own_mac          <= cfg_wr_data[47:0];
                CFG_SOURCE_IPV4: cfg_reg.source_ipv4      <= cfg_wr_data[31:0];
                CFG_SOURCE_IP6H: cfg_reg.source_ipv6_high <= cfg_wr_data;
                CFG_SOURCE_IP6L: cfg_reg.source_ipv6_low  <= cfg_wr_data;
                default:         cfg_reg <= cfg_reg;
            endcase
        end
    end

    assign s_req.kind        = s_opcode;
    assign s_req.target_high = s_target_high;
    assign s_req.target_low  = s_target_low;

    nrfb_csum u_csum (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg_reg),
        .in_valid  (s_valid),
        .in_ready  (s_ready),
        .in_req    (s_req),
        .out_valid (cs_valid),
        .out_ready (cs_ready),
        .out_req   (cs_req),
        .out_csum  (cs_csum)
    );

    nrfb_ser u_ser (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg           (cfg_reg),
        .in_valid      (cs_valid),
        .in_ready      (cs_ready),
        .in_req        (cs_req),
        .in_csum       (cs_csum),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_frame_word  (m_frame_word),
        .m_valid_bytes (m_valid_bytes),
        .m_last_word   (m_last_word)
    );

endmodule

`default_nettype wire

### rtl/nrfb_checker.sv
// Port-level checker for the frame builder, bound to the top level.
`default_nettype none

`include "neighbour_request_frame_builder_unit_assert.svh"

module nrfb_checker (
    input wire        aclk,
    input wire        aresetn,
    input wire        m_valid,
    input wire        m_ready,
    input wire [63:0] m_frame_word,
    input wire [3:0]  m_valid_bytes,
    input wire        m_last_word
);

    `NRFB_ASSERT_NEXT(a_out_hold, aclk, aresetn, m_valid && !m_ready, m_valid && $stable(m_frame_word), "stalled item changed")

    `NRFB_ASSERT_NOW(a_full_word, aclk, aresetn, m_valid && !m_last_word, m_valid_bytes == 4'd8, "inner word not full")

    `NRFB_ASSERT_NOW(a_last_len, aclk, aresetn, m_valid && m_last_word, m_valid_bytes == 4'd2 || m_valid_bytes == 4'd6, "bad final word length")

    // the lowest two bytes of a final word, padding for both frame kinds, are zero
    `NRFB_ASSERT_NOW(a_pad_zero, aclk, aresetn, m_valid && m_last_word, m_frame_word[15:0] == 16'h0, "nonzero padding")

endmodule

bind neighbour_request_frame_builder_unit nrfb_checker u_nrfb_checker (
    .aclk          (aclk),
    .aresetn       (aresetn),
    .m_valid       (m_valid),
    .m_ready       (m_ready),
    .m_frame_word  (m_frame_word),
    .m_valid_bytes (m_valid_bytes),
    .m_last_word   (m_last_word)
);

`default_nettype wire

### tb/neighbour_request_frame_builder_unit_test.sv
// Self-checking testbench for the ARP / neighbour solicitation frame builder.
`timescale 1ns / 1ps

module neighbour_request_frame_builder_unit_test;
    import nrfb_pkg::*;

    localparam int ARP_FRAME_BYTES = 42;
    localparam int NS_FRAME_BYTES  = 86;
    localparam int ARP_BITS        = 8 * ARP_FRAME_BYTES;
    localparam int NS_BITS         = 8 * NS_FRAME_BYTES;
    localparam int FRAME_BITS      = 704;
    localparam int SETTLE_CYCLES   = 8;
    localparam int DRAIN_CYCLES    = 20;
    localparam int WATCHDOG_LIMIT  = 1000;
    localparam int RANDOM_PHASES   = 4;
    localparam int ITEMS_PER_PHASE = 25;
    localparam int DIRECTED_ROWS   = 15;
    localparam int ALL_ONES_FROM   = 8;

    typedef struct packed {
        logic [63:0] word;
        logic [3:0]  nbytes;
        logic        last;
    } wire_word_t;

    typedef enum logic [1:0] {ROW_PREDICT, ROW_KNOWN, ROW_ZERO_CSUM} row_check_t;

    typedef struct packed {
        row_check_t       check;
        logic             kind;
        logic [63:0]      target_high;
        logic [63:0]      target_low;
        logic [0:5][63:0] known;
    } directed_row_t;

    // Rows before ALL_ONES_FROM run with reset settings (all zero), the rest with all ones.
    localparam directed_row_t DIRECTED [DIRECTED_ROWS] = '{
        '{ROW_KNOWN, KIND_ARP, 64'h0, 64'h0,
          '{64'hffff_ffff_ffff_0000, 64'h0000_0000_0806_0001, 64'h0800_0604_0001_0000,
            64'h0, 64'h0, 64'h0}},
        '{ROW_KNOWN, KIND_ARP, '1, '1,
          '{64'hffff_ffff_ffff_0000, 64'h0000_0000_0806_0001, 64'h0800_0604_0001_0000,
            64'h0, 64'h0000_0000_0000_ffff, 64'hffff_0000_0000_0000}},
        // upper half of target_low must not reach an ARP frame
        '{ROW_KNOWN, KIND_ARP, '1, 64'hffff_ffff_0000_0000,
          '{64'hffff_ffff_ffff_0000, 64'h0000_0000_0806_0001, 64'h0800_0604_0001_0000,
            64'h0, 64'h0, 64'h0}},
        '{ROW_PREDICT, KIND_NS, 64'h0, 64'h0, '0},
        '{ROW_PREDICT, KIND_NS, '1, '1, '0},
        '{ROW_PREDICT, KIND_NS, 64'h0, 64'h0000_0000_00ff_ffff, '0},
        '{ROW_PREDICT, KIND_NS, 64'h8000_0000_0000_0000, 64'h0000_0000_0000_0001, '0},
        '{ROW_ZERO_CSUM, KIND_NS, 64'h0000_1234_5678_9abc, 64'hfedc_ba98_7654_3210, '0},
        '{ROW_PREDICT, KIND_ARP, 64'h0, 64'h0, '0},
        '{ROW_PREDICT, KIND_ARP, '1, '1, '0},
        '{ROW_PREDICT, KIND_NS, 64'h0, 64'h0, '0},
        '{ROW_PREDICT, KIND_NS, '1, '1, '0},
        '{ROW_ZERO_CSUM, KIND_NS, 64'h0, 64'h0123_4567_89ab_cdef, '0},
        '{ROW_PREDICT, KIND_NS, 64'h5555_5555_5555_5555, 64'haaaa_aaaa_aaaa_aaaa, '0},
        '{ROW_PREDICT, KIND_ARP, 64'haaaa_aaaa_aaaa_aaaa, 64'h5555_5555_5555_5555, '0}
    };

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        cfg_wr_en = 1'b0;
    logic [1:0]  cfg_index = CFG_OWN_MAC;
    logic [63:0] cfg_wr_data = 64'h0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic        s_opcode = KIND_ARP;
    logic [63:0] s_target_high = 64'h0;
    logic [63:0] s_target_low = 64'h0;
    logic        m_valid;
    logic        m_ready = 1'b1;
    logic [63:0] m_frame_word;
    logic [3:0]  m_valid_bytes;
    logic        m_last_word;

    // mirror of the address registers
    logic [47:0] own_mac = '0;
    logic [31:0] own_ipv4 = '0;
    logic [63:0] own_ipv6_high = '0;
    logic [63:0] own_ipv6_low = '0;

    wire_word_t pending_words [$];
    logic quiet = 1'b0;
    int   stall_left = 0;
    int   idle_cycles = 0;
    int   error_count = 0;
    int   words_checked = 0;
    int   arp_count = 0;
    int   ns_count = 0;
    int   settings_count = 0;
    int   zero_csum_count = 0;

    neighbour_request_frame_builder_unit dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_index     (cfg_index),
        .cfg_wr_data   (cfg_wr_data),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_opcode      (s_opcode),
        .s_target_high (s_target_high),
        .s_target_low  (s_target_low),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_frame_word  (m_frame_word),
        .m_valid_bytes (m_valid_bytes),
        .m_last_word   (m_last_word)
    );

    always #1 aclk = ~aclk;

    function automatic logic [63:0] rand64();
        return {$urandom(), $urandom()};
    endfunction

    function automatic logic [ARP_BITS-1:0] arp_frame(input logic [63:0] tl);
        return {48'hffff_ffff_ffff, own_mac, 16'h0806, 16'h0001, 16'h0800, 8'd6, 8'd4,
                16'h0001, own_mac, own_ipv4, 48'h0, tl[31:0]};
    endfunction

    function automatic logic [NS_BITS-1:0] ns_frame(input logic [63:0] th,
                                                    input logic [63:0] tl,
                                                    input logic [15:0] csum);
        return {16'h3333, 8'hff, tl[23:0], own_mac, 16'h86dd, 8'h60, 24'h0, 16'd32, 8'd58,
                8'd255, own_ipv6_high, own_ipv6_low, 16'hff02, 72'h0, 8'h01, 8'hff, tl[23:0],
                8'd135, 8'd0, csum, 32'h0, th, tl, 8'h01, 8'h01, own_mac};
    endfunction

    // Folded ones-complement sum of pseudo-header and ICMPv6 body, checksum field zero.
    function automatic logic [15:0] ns_folded_sum(input logic [63:0] th, input logic [63:0] tl);
        logic [NS_BITS-1:0] f;
        logic [31:0] acc;
        int i;
        f = ns_frame(th, tl, 16'h0);
        acc = 32'd32 + 32'd58;
        for (i = 22; i < NS_FRAME_BYTES; i += 2)
            acc += {16'h0, f[NS_BITS-1-8*i -: 16]};
        while (acc > 32'hffff)
            acc = {16'h0, acc[15:0]} + {16'h0, acc[31:16]};
        return acc[15:0];
    endfunction

    // Pick the top target word so that the sum folds to ffff and the checksum is zero.
    function automatic logic [63:0] cancel_checksum(input logic [63:0] th, input logic [63:0] tl);
        logic [15:0] rest;
        rest = ns_folded_sum({16'h0, th[47:0]}, tl);
        zero_csum_count++;
        return {16'hffff - rest, th[47:0]};
    endfunction

    function automatic void predict_frame(input logic kind, input logic [63:0] th,
                                          input logic [63:0] tl);
        logic [FRAME_BITS-1:0] f;
        int len;
        int k;
        wire_word_t w;
        if (kind == KIND_NS) begin
            f = {ns_frame(th, tl, ~ns_folded_sum(th, tl)), {(FRAME_BITS-NS_BITS){1'b0}}};
            len = NS_FRAME_BYTES;
        end else begin
            f = {arp_frame(tl), {(FRAME_BITS-ARP_BITS){1'b0}}};
            len = ARP_FRAME_BYTES;
        end
        for (k = 0; 8 * k < len; k++) begin
            w.word = f[FRAME_BITS-1-64*k -: 64];
            w.nbytes = (len - 8 * k > 8) ? FULL_BYTES : 4'(len - 8 * k);
            w.last = (8 * k + 8 >= len);
            pending_words.push_back(w);
        end
    endfunction

    task automatic send_request(input logic kind, input logic [63:0] th, input logic [63:0] tl);
        int gap;
        if (!quiet && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 9);
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_opcode <= kind;
        s_target_high <= th;
        s_target_low <= tl;
        do @(posedge aclk); while (!s_ready);
        if (kind == KIND_NS) ns_count++;
        else arp_count++;
    endtask

    // Stop sending and let every outstanding frame leave the block.
    task automatic settle();
        s_valid <= 1'b0;
        while (pending_words.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [63:0] data);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wr_data <= data;
        @(posedge aclk);
        case (idx)
            CFG_OWN_MAC:     own_mac = data[47:0];
            CFG_SOURCE_IPV4: own_ipv4 = data[31:0];
            CFG_SOURCE_IP6H: own_ipv6_high = data;
            default:         own_ipv6_low = data;
        endcase
    endtask

    task automatic load_settings(input logic [63:0] mac, input logic [63:0] ip4,
                                 input logic [63:0] ip6h, input logic [63:0] ip6l);
        settle();
        write_reg(CFG_OWN_MAC, mac);
        write_reg(CFG_SOURCE_IPV4, ip4);
        write_reg(CFG_SOURCE_IP6H, ip6h);
        write_reg(CFG_SOURCE_IP6L, ip6l);
        cfg_wr_en <= 1'b0;
        settings_count++;
    endtask

    // receiver backpressure in random bursts
    always @(posedge aclk) begin
        if (!aresetn || quiet) begin
            m_ready <= 1'b1;
            stall_left <= 0;
        end else if (stall_left != 0) begin
            stall_left <= stall_left - 1;
            m_ready <= (stall_left == 1);
        end else if ($urandom_range(0, 9) == 0) begin
            stall_left <= $urandom_range(1, 9);
            m_ready <= 1'b0;
        end else begin
            m_ready <= 1'b1;
        end
    end

    // result checking and watchdog
    always @(posedge aclk) begin
        wire_word_t want;
        if (aresetn) begin
            if ((s_valid && s_ready) || (m_valid && m_ready)) begin
                idle_cycles <= 0;
            end else if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("CHECKS FAILED");
                $finish;
            end else begin
                idle_cycles <= idle_cycles + 1;
            end
            if (m_valid && m_ready) begin
                if (pending_words.size() == 0) begin
                    $error("unexpected frame word %h", m_frame_word);
                    error_count++;
                end else begin
                    want = pending_words.pop_front();
                    words_checked++;
                    if (m_frame_word !== want.word) begin
                        $error("frame_word: expected %h, actual %h", want.word, m_frame_word);
                        error_count++;
                    end
                    if (m_valid_bytes !== want.nbytes) begin
                        $error("valid_bytes: expected %0d, actual %0d", want.nbytes,
                               m_valid_bytes);
                        error_count++;
                    end
                    if (m_last_word !== want.last) begin
                        $error("last_word: expected %b, actual %b", want.last, m_last_word);
                        error_count++;
                    end
                end
            end
        end
    end

    initial begin
        directed_row_t row;
        wire_word_t w;
        logic kind;
        logic [63:0] th;
        logic [63:0] tl;
        int i;
        int k;
        int phase;
        int pick;

        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        for (i = 0; i < DIRECTED_ROWS; i++) begin
            row = DIRECTED[i];
            if (i == ALL_ONES_FROM) load_settings('1, '1, '1, '1);
            th = row.target_high;
            if (row.check == ROW_ZERO_CSUM) th = cancel_checksum(th, row.target_low);
            send_request(row.kind, th, row.target_low);
            if (row.check == ROW_KNOWN) begin
                for (k = 0; k <= ARP_LAST_IDX; k++) begin
                    w.word = row.known[k];
                    w.nbytes = (k == ARP_LAST_IDX) ? ARP_LAST_BYTES : FULL_BYTES;
                    w.last = (k == ARP_LAST_IDX);
                    pending_words.push_back(w);
                end
            end else begin
                predict_frame(row.kind, th, row.target_low);
            end
        end

        for (phase = 0; phase < RANDOM_PHASES; phase++) begin
            if (phase == RANDOM_PHASES - 1) quiet <= 1'b1;
            if (phase == 1)
                load_settings(64'h5555_aaaa_aaaa_5555, 64'haaaa_aaaa_5555_5555,
                              64'h5555_5555_aaaa_aaaa, 64'haaaa_5555_aaaa_5555);
            else
                load_settings(rand64(), rand64(), rand64(), rand64());
            for (i = 0; i < ITEMS_PER_PHASE; i++) begin
                kind = 1'($urandom_range(0, 1));
                th = rand64();
                tl = rand64();
                pick = $urandom_range(0, 9);
                if (pick == 0) begin
                    th = '0;
                    tl = '0;
                end else if (pick == 1) begin
                    th = '1;
                    tl = '1;
                end else if (pick == 2 && kind == KIND_NS) begin
                    th = cancel_checksum(th, tl);
                end
                send_request(kind, th, tl);
                predict_frame(kind, th, tl);
            end
        end

        s_valid <= 1'b0;
        while (pending_words.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("Sent %0d ARP and %0d solicitation requests; %0d frame words compared.",
                 arp_count, ns_count, words_checked);
        $display("Address settings used: %0d (zero and all-ones among them), %0d zero checksums.",
                 settings_count + 1, zero_csum_count);
        if (error_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

### sim.f
+incdir+rtl
rtl/nrfb_pkg.sv
rtl/nrfb_csum.sv
rtl/nrfb_ser.sv
rtl/neighbour_request_frame_builder_unit.sv
rtl/nrfb_checker.sv
tb/neighbour_request_frame_builder_unit_test.sv
